>>> sv/brf_pkg.sv
package brf_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 63;
	localparam int NUM_IMAGES = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_BOX_X    = 3'd3,
		REG_BOX_Y    = 3'd4,
		REG_BOX_Z    = 3'd5,
		REG_CUTOFF   = 3'd6,
		REG_MAXF     = 3'd7
	} reg_idx_t;

	// shift code per image and axis: 0 none, 1 plus box, 2 minus box
	typedef enum logic [1:0] {
		SH_NONE  = 2'd0,
		SH_PLUS  = 2'd1,
		SH_MINUS = 2'd2
	} shift_t;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic [30:0] box_x;
		logic [30:0] box_y;
		logic [30:0] box_z;
		logic [62:0] cutoff_sq;
		logic [30:0] max_force;
	} cfg_t;

	typedef struct packed {
		logic in_cut;
		logic clr;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] dz;
		logic [62:0] d2;
	} entry_t;

	function automatic shift_t img_shift(input logic [2:0] img, input logic [1:0] axis);
		shift_t s;
		s = SH_NONE;
		case (img)
			3'd1: if (axis == 2'd0) s = SH_PLUS;
			3'd2: if (axis == 2'd1) s = SH_PLUS;
			3'd3: if (axis == 2'd2) s = SH_PLUS;
			3'd4: if (axis == 2'd0) s = SH_MINUS;
			3'd5: if (axis == 2'd1) s = SH_MINUS;
			3'd6: if (axis == 2'd2) s = SH_MINUS;
			default: s = SH_NONE;
		endcase
		return s;
	endfunction

endpackage

>>> sv/brf_if.sv
interface brf_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic is_selected;
	logic bubble_growing;
	logic first_of_pass;
	modport source(output valid, pos_x, pos_y, pos_z, is_selected, bubble_growing,
		first_of_pass, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, is_selected, bubble_growing,
		first_of_pass, output ready);
endinterface

interface brf_out_if;
	logic valid;
	logic ready;
	logic in_bubble;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic signed [31:0] force_z;
	logic [31:0] hits_so_far;
	modport source(output valid, in_bubble, force_x, force_y, force_z, hits_so_far,
		input ready);
	modport sink(input valid, in_bubble, force_x, force_y, force_z, hits_so_far,
		output ready);
endinterface

>>> sv/brf_front.sv
module brf_front import brf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	brf_in_if.sink in_ch,
	output logic push,
	output entry_t push_data,
	input  logic full
);

	typedef enum logic [2:0] {FR_IDLE, FR_DIFF, FR_SQ, FR_CMP, FR_PUSH} fr_state_t;

	fr_state_t state_q;
	logic [2:0] img_q;
	logic signed [31:0] pos_q [3];
	logic clr_q, inside_q;
	logic signed [34:0] d_q [3];
	logic [31:0] mag_q [3];
	logic big_q;
	logic [63:0] sq_q [3];
	logic [62:0] d2_q;

	logic signed [34:0] d_n [3];
	logic [34:0] abs_n [3];
	logic signed [31:0] ctr [3];
	logic [30:0] box [3];
	logic [65:0] sum;
	logic [63:0] d2_n;
	logic hit_n;
	logic big_n;

	assign ctr[0] = cfg.center_x;
	assign ctr[1] = cfg.center_y;
	assign ctr[2] = cfg.center_z;
	assign box[0] = cfg.box_x;
	assign box[1] = cfg.box_y;
	assign box[2] = cfg.box_z;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [34:0] sh;
			case (img_shift(img_q, 2'(k)))
				SH_PLUS:  sh = $signed({4'b0, box[k]});
				SH_MINUS: sh = -$signed({4'b0, box[k]});
				default:  sh = '0;
			endcase
			d_n[k] = 35'(pos_q[k]) + sh - 35'(ctr[k]);
			abs_n[k] = d_n[k][34] ? 35'(-d_n[k]) : 35'(d_n[k]);
		end
		// any component at or above 2^32 saturates d2
		big_n = (abs_n[0][34:32] != 3'b0) || (abs_n[1][34:32] != 3'b0) ||
			(abs_n[2][34:32] != 3'b0);
		sum = 66'(sq_q[0]) + 66'(sq_q[1]) + 66'(sq_q[2]);
		d2_n = (big_q || (sum[65:64] != 2'b0)) ? '1 : sum[63:0];
		hit_n = d2_n < {1'b0, cfg.cutoff_sq};
	end

	assign in_ch.ready = (state_q == FR_IDLE);
	assign push = (state_q == FR_PUSH) && !full;

	always_comb begin
		push_data.in_cut = inside_q;
		push_data.clr = clr_q;
		push_data.dx = d_q[0][32:0];
		push_data.dy = d_q[1][32:0];
		push_data.dz = d_q[2][32:0];
		push_data.d2 = d2_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			case (state_q)
				FR_IDLE: if (in_ch.valid) begin
					pos_q[0] <= in_ch.pos_x;
					pos_q[1] <= in_ch.pos_y;
					pos_q[2] <= in_ch.pos_z;
					clr_q <= in_ch.first_of_pass;
					inside_q <= 1'b0;
					img_q <= '0;
					state_q <= (in_ch.bubble_growing && !in_ch.is_selected) ? FR_DIFF : FR_PUSH;
				end
				FR_DIFF: begin
					big_q <= big_n;
					for (int k = 0; k < 3; k++) begin
						d_q[k] <= d_n[k];
						mag_q[k] <= abs_n[k][31:0];
					end
					state_q <= FR_SQ;
				end
				FR_SQ: begin
					for (int k = 0; k < 3; k++) sq_q[k] <= mag_q[k] * mag_q[k];
					state_q <= FR_CMP;
				end
				FR_CMP: begin
					d2_q <= d2_n[62:0];
					if (hit_n) begin
						inside_q <= 1'b1;
						state_q <= FR_PUSH;
					end else if (img_q == 3'(NUM_IMAGES - 1)) begin
						state_q <= FR_PUSH;
					end else begin
						img_q <= img_q + 3'd1;
						state_q <= FR_DIFF;
					end
				end
				FR_PUSH: if (!full) state_q <= FR_IDLE;
				default: state_q <= FR_IDLE;
			endcase
		end
	end

endmodule

>>> sv/brf_queue.sv
module brf_queue import brf_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  entry_t push_data,
	output logic full,
	input  logic pop,
	output entry_t pop_data,
	output logic not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	entry_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue write while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("queue read while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH))
		else $error("queue count out of range");

endmodule

>>> sv/brf_back.sv
module brf_back import brf_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic not_empty,
	input  entry_t pop_data,
	output logic pop,
	brf_out_if.source out_ch
);

	typedef enum logic [2:0] {BK_IDLE, BK_DIV, BK_MUL1, BK_MUL2, BK_FIN, BK_DONE} bk_state_t;

	localparam int DIV_STEPS = 32;

	bk_state_t state_q;
	entry_t ent_q;
	logic [64:0] rem_q;
	logic [32:0] quo_q;
	logic [5:0] step_q;
	logic [1:0] comp_q;
	logic [62:0] m_q;
	logic [63:0] hi_q;
	logic [64:0] lo_q;
	logic [31:0] frc_q [3];
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic out_valid_q;
	logic out_bub_q;
	logic [31:0] out_f_q [3];
	logic [31:0] out_hits_q;

	logic [64:0] rem_sh, rem_nx;
	logic [32:0] quo_nx;
	logic signed [32:0] dsel;
	logic [31:0] dmag;
	logic [63:0] fmag;
	logic [31:0] fsat;
	logic [COUNT_WIDTH-1:0] cnt_n;
	logic [63:0] cnt_ext;

	always_comb begin
		// first step compares without shifting, the rest shift then compare
		rem_sh = (step_q == '0) ? rem_q : {rem_q[63:0], 1'b0};
		quo_nx = (step_q == '0) ? quo_q : {quo_q[31:0], 1'b0};
		rem_nx = rem_sh;
		if (rem_sh >= {2'b0, cfg.cutoff_sq}) begin
			rem_nx = rem_sh - {2'b0, cfg.cutoff_sq};
			quo_nx[0] = 1'b1;
		end
	end

	always_comb begin
		case (comp_q)
			2'd0: dsel = ent_q.dx;
			2'd1: dsel = ent_q.dy;
			default: dsel = ent_q.dz;
		endcase
		dmag = dsel[32] ? 32'(-dsel) : dsel[31:0];
		fmag = (hi_q >> 16) + 64'((33'(hi_q[15:0]) + lo_q[64:32]) >> 16);
		if (dsel[32])
			fsat = (fmag > 64'h8000_0000) ? 32'h8000_0000 : 32'(-fmag[31:0]);
		else
			fsat = (fmag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : fmag[31:0];
	end

	always_comb begin
		cnt_n = (ent_q.clr ? '0 : cnt_q) + COUNT_WIDTH'(ent_q.in_cut);
		cnt_ext = 64'(cnt_n);
	end

	assign pop = (state_q == BK_IDLE) && not_empty && !out_valid_q;

	assign out_ch.valid = out_valid_q;
	assign out_ch.in_bubble = out_bub_q;
	assign out_ch.force_x = out_f_q[0];
	assign out_ch.force_y = out_f_q[1];
	assign out_ch.force_z = out_f_q[2];
	assign out_ch.hits_so_far = out_hits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				BK_IDLE: if (pop) begin
					ent_q <= pop_data;
					rem_q <= 65'({1'b0, cfg.cutoff_sq} - {1'b0, pop_data.d2});
					quo_q <= '0;
					step_q <= '0;
					comp_q <= '0;
					for (int k = 0; k < 3; k++) frc_q[k] <= '0;
					state_q <= pop_data.in_cut ? BK_DIV : BK_DONE;
				end
				BK_DIV: begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					step_q <= step_q + 6'd1;
					if (step_q == 6'(DIV_STEPS)) state_q <= BK_MUL1;
				end
				BK_MUL1: begin
					m_q <= dmag * cfg.max_force;
					state_q <= BK_MUL2;
				end
				BK_MUL2: begin
					hi_q <= m_q[62:32] * quo_q;
					lo_q <= m_q[31:0] * quo_q;
					state_q <= BK_FIN;
				end
				BK_FIN: begin
					frc_q[comp_q] <= fsat;
					comp_q <= comp_q + 2'd1;
					state_q <= (comp_q == 2'd2) ? BK_DONE : BK_MUL1;
				end
				BK_DONE: begin
					cnt_q <= cnt_n;
					out_valid_q <= 1'b1;
					out_bub_q <= ent_q.in_cut;
					for (int k = 0; k < 3; k++) out_f_q[k] <= frc_q[k];
					out_hits_q <= cnt_ext[31:0];
					state_q <= BK_IDLE;
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	a_div_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> ent_q.in_cut)
		else $error("division started for an item outside the cutoff");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DONE) |-> !out_valid_q)
		else $error("result overwrites a pending word");
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_MUL1) |-> (quo_q <= 33'h1_0000_0000))
		else $error("force factor above one");

endmodule

>>> sv/bubble_repulsion_force.sv
// channel | dir | word
// in_ch   | in  | pos_x, pos_y, pos_z, is_selected, bubble_growing, first_of_pass
// out_ch  | out | in_bubble, force_x, force_y, force_z, hits_so_far
// cfg     | in  | cfg_we, cfg_idx, cfg_wdata (write only)
//
// Front tests the periodic images in turn, each by difference, square and compare,
// stopping at the first hit; a skipped word goes straight to the queue. Back: a
// miss or skipped word goes straight to the result; a hit runs the bit-serial divider,
// then the shared force multiplier for each axis. Back waits while a result word is pending.
// A two-entry queue between front and back lets each run while the other stalls.
// arst_n clears control state, config registers and the hit counter.
module bubble_repulsion_force import brf_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	brf_in_if.sink in_ch,
	brf_out_if.source out_ch
);

	cfg_t cfg_q;
	logic push, full, pop, not_empty;
	entry_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_CENTER_X: cfg_q.center_x <= cfg_wdata[31:0];
				REG_CENTER_Y: cfg_q.center_y <= cfg_wdata[31:0];
				REG_CENTER_Z: cfg_q.center_z <= cfg_wdata[31:0];
				REG_BOX_X:    cfg_q.box_x <= cfg_wdata[30:0];
				REG_BOX_Y:    cfg_q.box_y <= cfg_wdata[30:0];
				REG_BOX_Z:    cfg_q.box_z <= cfg_wdata[30:0];
				REG_CUTOFF:   cfg_q.cutoff_sq <= cfg_wdata[62:0];
				REG_MAXF:     cfg_q.max_force <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	brf_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .in_ch(in_ch),
		.push(push), .push_data(push_data), .full(full)
	);

	brf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data), .full(full),
		.pop(pop), .pop_data(pop_data), .not_empty(not_empty)
	);

	brf_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .not_empty(not_empty),
		.pop_data(pop_data), .pop(pop), .out_ch(out_ch)
	);

endmodule
